FILE: src/uvs_pkg.sv
// ---------------------------------------------------------------------------
// UV sphere vertex generator package
// Shared widths, register indexes, reset values and the constants of the
// fixed-point sine series used by the vertex pipeline.
// ---------------------------------------------------------------------------
package uvs_pkg;

	// Field and datapath widths
	localparam int INDEX_W    = 8;
	localparam int COUNT_W    = 9;
	localparam int RADIUS_W   = 16;
	localparam int OUT_W      = 17;
	localparam int CORNER_W   = 3;
	localparam int PHASE_W    = 32;
	localparam int QUO_W      = 33;   // floor(2^32 / count)
	localparam int QFULL_W    = 41;   // floor(index * 2^32 / count)
	localparam int XPROD_W    = 18;   // index * remainder
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STACK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE  = 2'd2;

	// Reset values
	localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd256;
	localparam logic [COUNT_W-1:0]  COUNT_RST  = 9'd16;

	// Corner sequence of one quad: stack and slice offsets per corner
	localparam int NUM_CORNERS = 6;
	localparam logic [CORNER_W-1:0] CORNER_LAST = 3'd5;
	localparam logic CORNER_DI [NUM_CORNERS] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
	localparam logic CORNER_DJ [NUM_CORNERS] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

	// Q2.30 sine series constants
	localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
	localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
	localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [OUT_W-1:0]   TEX_ONE      = 17'h1_0000;

	// Horner divisors, highest power first, and their floor(2^32 / k)
	localparam int HORNER_N = 5;
	localparam logic [6:0] HORNER_K [HORNER_N] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
	localparam logic [31:0] HORNER_M [HORNER_N] = '{
		32'((64'd1 << 32) / 64'd110),
		32'((64'd1 << 32) / 64'd72),
		32'((64'd1 << 32) / 64'd42),
		32'((64'd1 << 32) / 64'd20),
		32'((64'd1 << 32) / 64'd6)
	};

	// Sine unit stages: fold, angle, square, three per Horner step, final product, round
	localparam int SIN_LAT = 3 + 3 * HORNER_N + 2;

endpackage

FILE: src/uvs_recip.sv
// ---------------------------------------------------------------------------
// Count reciprocal unit
// Bit-serial restoring division of 2^32 by a grid count: one quotient bit
// per cycle. Restarts on every write of its count.
// ---------------------------------------------------------------------------
module uvs_recip (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         restart,
	input  logic [uvs_pkg::COUNT_W-1:0]  divisor,
	output logic [uvs_pkg::QUO_W-1:0]    quotient,
	output logic [uvs_pkg::COUNT_W-1:0]  remainder,
	output logic                         busy
);

	localparam logic [5:0] STEPS = 6'(uvs_pkg::QUO_W);

	logic [5:0]                    cnt_q;
	logic [uvs_pkg::COUNT_W-1:0]   rem_q;
	logic [uvs_pkg::QUO_W-1:0]     quo_q;
	logic [uvs_pkg::COUNT_W:0]     shifted;
	logic                          ge;
	logic [uvs_pkg::COUNT_W:0]     diff;

	// Dividend is 2^32: only its top bit is set
	assign shifted = {rem_q, (cnt_q == STEPS)};
	assign ge      = shifted >= {1'b0, divisor};
	assign diff    = shifted - {1'b0, divisor};

	// Step counter and partial remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= STEPS;
			rem_q <= '0;
		end else if (restart) begin
			cnt_q <= STEPS;
			rem_q <= '0;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
			rem_q <= ge ? diff[uvs_pkg::COUNT_W-1:0] : shifted[uvs_pkg::COUNT_W-1:0];
		end
	end

	// Quotient bits shift in MSB first
	always_ff @(posedge clk) begin
		if (!restart && cnt_q != 6'd0) begin
			quo_q <= {quo_q[uvs_pkg::QUO_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign busy      = (cnt_q != 6'd0);

endmodule

FILE: src/uvs_sine.sv
// ---------------------------------------------------------------------------
// Pipelined sine unit
// Sine of a 32-bit turn phase as sign and magnitude with TRIG_BITS-1
// fraction bits. Quadrant fold, then a truncated Q2.30 odd series in
// Horner form, at most one multiply per stage.
// ---------------------------------------------------------------------------
module uvs_sine #(
	parameter int TRIG_BITS = 16
) (
	input  logic                          clk,
	input  logic [uvs_pkg::PHASE_W-1:0]   phase,
	output logic [TRIG_BITS-1:0]          mag,
	output logic                          neg
);

	localparam int F = TRIG_BITS - 1;

	typedef struct packed {
		logic [30:0] t;
		logic [31:0] t2;
		logic        sat;
		logic        neg;
	} ctx_t;

	logic [30:0] farg_s1;
	logic        sat_s1;
	logic        neg_s1;
	logic [30:0] t_s2;
	logic        sat_s2;
	logic        neg_s2;
	ctx_t        ctx_s3;
	logic [60:0] t_full;
	logic [61:0] t2_full;

	logic [30:0] s_st   [uvs_pkg::HORNER_N+1];
	ctx_t        ctx_st [uvs_pkg::HORNER_N+1];

	logic [61:0]   fin_full;
	logic [30:0]   sfin_s19;
	logic          sat_s19;
	logic          neg_s19;
	logic [TRIG_BITS-1:0] mag_s20;
	logic          neg_s20;
	logic [TRIG_BITS-1:0] mag_next;

	// Stage 1: fold into the first quadrant
	always_ff @(posedge clk) begin
		farg_s1 <= phase[30] ? (uvs_pkg::Q30_ONE - {1'b0, phase[29:0]})
		                     : {1'b0, phase[29:0]};
		sat_s1  <= phase[30] && (phase[29:0] == 30'd0);
		neg_s1  <= phase[31];
	end

	// Stage 2: quarter-turn fraction to radians
	assign t_full = {31'd0, farg_s1[29:0]} * {30'd0, uvs_pkg::HALF_PI_Q30};
	always_ff @(posedge clk) begin
		t_s2   <= t_full[60:30];
		sat_s2 <= sat_s1;
		neg_s2 <= neg_s1;
	end

	// Stage 3: square of the angle
	assign t2_full = {31'd0, t_s2} * {31'd0, t_s2};
	always_ff @(posedge clk) begin
		ctx_s3.t   <= t_s2;
		ctx_s3.t2  <= t2_full[61:30];
		ctx_s3.sat <= sat_s2;
		ctx_s3.neg <= neg_s2;
	end

	assign s_st[0]   = uvs_pkg::Q30_ONE;
	assign ctx_st[0] = ctx_s3;

	// Horner steps: s = 1 - ((t2 * s) >> 30) / k, three stages each
	for (genvar k = 0; k < uvs_pkg::HORNER_N; k++) begin : g_step
		logic [62:0] x_full;
		logic [63:0] qe_full;
		logic [38:0] qk_full;
		logic [31:0] x_sa;
		ctx_t        c_sa;
		logic [31:0] qe_sb;
		logic [31:0] x_sb;
		ctx_t        c_sb;
		logic [31:0] r;
		logic [31:0] q;
		logic [30:0] s_sc;
		ctx_t        c_sc;

		// product with the running sum
		assign x_full = {31'd0, ctx_st[k].t2} * {32'd0, s_st[k]};
		always_ff @(posedge clk) begin
			x_sa <= x_full[61:30];
			c_sa <= ctx_st[k];
		end

		// quotient estimate by reciprocal, low by at most one
		assign qe_full = {32'd0, x_sa} * {32'd0, uvs_pkg::HORNER_M[k]};
		always_ff @(posedge clk) begin
			qe_sb <= qe_full[63:32];
			x_sb  <= x_sa;
			c_sb  <= c_sa;
		end

		// correct the estimate, subtract from one
		assign qk_full = {7'd0, qe_sb} * {32'd0, uvs_pkg::HORNER_K[k]};
		assign r       = x_sb - qk_full[31:0];
		assign q       = qe_sb + {31'd0, (r >= {25'd0, uvs_pkg::HORNER_K[k]})};
		always_ff @(posedge clk) begin
			s_sc <= uvs_pkg::Q30_ONE - q[30:0];
			c_sc <= c_sb;
		end

		assign s_st[k+1]   = s_sc;
		assign ctx_st[k+1] = c_sc;
	end

	// Final odd factor
	assign fin_full = {31'd0, ctx_st[uvs_pkg::HORNER_N].t} * {31'd0, s_st[uvs_pkg::HORNER_N]};
	always_ff @(posedge clk) begin
		sfin_s19 <= fin_full[60:30];
		sat_s19  <= ctx_st[uvs_pkg::HORNER_N].sat;
		neg_s19  <= ctx_st[uvs_pkg::HORNER_N].neg;
	end

	// Truncate to F fraction bits; a quarter-turn point is exactly one
	assign mag_next = sat_s19 ? {1'b1, {F{1'b0}}} : sfin_s19[30:30-F];
	always_ff @(posedge clk) begin
		mag_s20 <= mag_next;
		neg_s20 <= neg_s19 && (mag_next != '0);
	end

	assign mag = mag_s20;
	assign neg = neg_s20;

endmodule

FILE: src/uvs_delay.sv
// ---------------------------------------------------------------------------
// Sideband delay line
// Carries a valid bit and a data word alongside a fixed-latency unit.
// ---------------------------------------------------------------------------
module uvs_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         d_valid,
	input  logic [W-1:0] d_data,
	output logic         q_valid,
	output logic [W-1:0] q_data
);

	logic         valid_q [DEPTH];
	logic [W-1:0] data_q  [DEPTH];

	// Valid taps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < DEPTH; n++) begin
				valid_q[n] <= 1'b0;
			end
		end else begin
			valid_q[0] <= d_valid;
			for (int n = 1; n < DEPTH; n++) begin
				valid_q[n] <= valid_q[n-1];
			end
		end
	end

	// Data taps
	always_ff @(posedge clk) begin
		data_q[0] <= d_data;
		for (int n = 1; n < DEPTH; n++) begin
			data_q[n] <= data_q[n-1];
		end
	end

	assign q_valid = valid_q[DEPTH-1];
	assign q_data  = data_q[DEPTH-1];

endmodule

FILE: src/uv_sphere_vertex_generator_unit.sv
// ---------------------------------------------------------------------------
// UV sphere vertex generator
// Takes one quad (stack, slice) and emits the six vertices of its two
// triangles: position from radius and sine/cosine of the grid angles,
// texture coordinates from grid index over count.
//
// Channel    Signals                                        Handshake
// config     cfg_wr_en, cfg_index, cfg_data                 write on cfg_wr_en
// quad in    stack_index, slice_index                       start && !busy
// vertex out pos_x/y/z, tex_u/v, corner, last               vertex_valid, 1 cycle
//
// The corner sequencer issues the six vertices of a quad one per cycle
// into the pipeline, and a new quad is taken on the cycle of the sixth.
// After reset and after a write to stack_count or slice_count, busy holds
// while the serial reciprocal unit divides 2^32 by the count.
// Results cannot be held off; the pipeline never stalls.
// ---------------------------------------------------------------------------
module uv_sphere_vertex_generator_unit #(
	parameter int MAX_STACKS = 256,
	parameter int MAX_SLICES = 256,
	parameter int TRIG_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_wr_en,
	input  logic [uvs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [uvs_pkg::CFG_DATA_W-1:0]     cfg_data,
	// quad request
	input  logic                               start,
	output logic                               busy,
	input  logic [uvs_pkg::INDEX_W-1:0]        stack_index,
	input  logic [uvs_pkg::INDEX_W-1:0]        slice_index,
	// vertex result
	output logic                               vertex_valid,
	output logic signed [uvs_pkg::OUT_W-1:0]   pos_x,
	output logic signed [uvs_pkg::OUT_W-1:0]   pos_y,
	output logic signed [uvs_pkg::OUT_W-1:0]   pos_z,
	output logic [uvs_pkg::OUT_W-1:0]          tex_u,
	output logic [uvs_pkg::OUT_W-1:0]          tex_v,
	output logic [uvs_pkg::CORNER_W-1:0]       corner,
	output logic                               last
);

	localparam int F   = TRIG_BITS - 1;
	localparam int RW  = uvs_pkg::RADIUS_W;
	localparam int CW  = uvs_pkg::COUNT_W;
	localparam int IW  = uvs_pkg::INDEX_W;
	localparam int QW  = uvs_pkg::QUO_W;
	localparam int FW  = uvs_pkg::QFULL_W;
	localparam int XW  = uvs_pkg::XPROD_W;
	localparam int PW  = uvs_pkg::PHASE_W;
	localparam int OW  = uvs_pkg::OUT_W;
	localparam int KW  = uvs_pkg::CORNER_W;
	localparam logic [CW-1:0] STACK_CAP = CW'((MAX_STACKS > 511) ? 511 : MAX_STACKS);
	localparam logic [CW-1:0] SLICE_CAP = CW'((MAX_SLICES > 511) ? 511 : MAX_SLICES);

	typedef struct packed {
		logic [OW-1:0] tex_u;
		logic [OW-1:0] tex_v;
		logic [KW-1:0] corner;
		logic          last;
	} side_t;

	// Configuration registers
	logic [RW-1:0] radius_q;
	logic [CW-1:0] stack_q;
	logic [CW-1:0] slice_q;
	logic [CW-1:0] stack_eff;
	logic [CW-1:0] slice_eff;
	logic          wr_stack;
	logic          wr_slice;

	// Reciprocals of the counts
	logic [QW-1:0] base_v;
	logic [CW-1:0] rem_v;
	logic          busy_v;
	logic [QW-1:0] base_u;
	logic [CW-1:0] rem_u;
	logic          busy_u;

	// Corner sequencer
	logic          accept;
	logic          act_q;
	logic [KW-1:0] cnt_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;

	// Pipeline
	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [CW-1:0] a_s1, b_s1;
	logic [KW-1:0] corner_s1, corner_s2, corner_s3, corner_s4;
	logic          last_s1, last_s2, last_s3, last_s4;
	logic [FW:0]   hv_full, hu_full;
	logic [XW-1:0] xv_full, xu_full;
	logic [FW-1:0] hv_s2, hu_s2, hv_s3, hu_s3;
	logic [XW-1:0] xv_s2, xu_s2, xv_s3, xu_s3;
	logic [XW+QW-1:0] qev_full, qeu_full;
	logic [XW-1:0] qev_s3, qeu_s3;
	logic [XW+CW-1:0] qcv_full, qcu_full;
	logic [XW-1:0] rv, ru;
	logic [XW-1:0] qv_fix, qu_fix;
	logic [FW-1:0] qv_s4, qu_s4;
	logic [FW-17:0] tv_hi, tu_hi;
	logic [PW-1:0] ph_sp_s5, ph_cp_s5, ph_sa_s5, ph_ca_s5;
	side_t         side_s5;
	side_t         side_d, side_s6, side_s7;
	logic          v_d;

	logic [TRIG_BITS-1:0] sp_mag, cp_mag, sa_mag, ca_mag;
	logic                 sp_neg, cp_neg, sa_neg, ca_neg;

	logic [RW+TRIG_BITS-1:0]     rsp_full, rcp_full;
	logic [RW+TRIG_BITS-1:0]     rsp_s6;
	logic [RW-1:0]               my_s6, my_s7;
	logic [TRIG_BITS-1:0]        sa_s6, ca_s6;
	logic                        nsp_s6, ncp_s6, nsa_s6, nca_s6;
	logic [RW+2*TRIG_BITS-1:0]   mx_full, mz_full;
	logic [RW-1:0]               mx_s7, mz_s7;
	logic                        nx_s7, ny_s7, nz_s7;
	logic [OW-1:0]               px_s8, py_s8, pz_s8;
	side_t                       side_s8;

	// Register writes
	assign wr_stack = cfg_wr_en && (cfg_index == uvs_pkg::REG_STACK);
	assign wr_slice = cfg_wr_en && (cfg_index == uvs_pkg::REG_SLICE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= uvs_pkg::RADIUS_RST;
			stack_q  <= uvs_pkg::COUNT_RST;
			slice_q  <= uvs_pkg::COUNT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				uvs_pkg::REG_RADIUS: radius_q <= cfg_data[RW-1:0];
				uvs_pkg::REG_STACK:  stack_q  <= cfg_data[CW-1:0];
				uvs_pkg::REG_SLICE:  slice_q  <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// Effective counts: zero acts as one, clamp at the maximum
	assign stack_eff = (stack_q == '0) ? CW'(1) : ((stack_q > STACK_CAP) ? STACK_CAP : stack_q);
	assign slice_eff = (slice_q == '0) ? CW'(1) : ((slice_q > SLICE_CAP) ? SLICE_CAP : slice_q);

	uvs_recip u_recip_v (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (wr_stack),
		.divisor   (stack_eff),
		.quotient  (base_v),
		.remainder (rem_v),
		.busy      (busy_v)
	);

	uvs_recip u_recip_u (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (wr_slice),
		.divisor   (slice_eff),
		.quotient  (base_u),
		.remainder (rem_u),
		.busy      (busy_u)
	);

	// Quad accept: free on the cycle the sixth corner issues, unless a reciprocal is busy
	assign busy   = busy_v || busy_u || (act_q && (cnt_q != uvs_pkg::CORNER_LAST));
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
		end else if (accept) begin
			act_q <= 1'b1;
			cnt_q <= '0;
		end else if (act_q) begin
			if (cnt_q == uvs_pkg::CORNER_LAST) begin
				act_q <= 1'b0;
			end
			cnt_q <= cnt_q + KW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			i_q <= stack_index;
			j_q <= slice_index;
		end
	end

	// Valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= act_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: grid point of this corner
	always_ff @(posedge clk) begin
		a_s1      <= {1'b0, i_q} + {{(CW-1){1'b0}}, uvs_pkg::CORNER_DI[cnt_q]};
		b_s1      <= {1'b0, j_q} + {{(CW-1){1'b0}}, uvs_pkg::CORNER_DJ[cnt_q]};
		corner_s1 <= cnt_q;
		last_s1   <= (cnt_q == uvs_pkg::CORNER_LAST);
	end

	// Stage 2: index * floor(2^32/c) and index * (2^32 mod c)
	assign hv_full = {{(FW+1-CW){1'b0}}, a_s1} * {{(FW+1-QW){1'b0}}, base_v};
	assign hu_full = {{(FW+1-CW){1'b0}}, b_s1} * {{(FW+1-QW){1'b0}}, base_u};
	assign xv_full = {{(XW-CW){1'b0}}, a_s1} * {{(XW-CW){1'b0}}, rem_v};
	assign xu_full = {{(XW-CW){1'b0}}, b_s1} * {{(XW-CW){1'b0}}, rem_u};

	always_ff @(posedge clk) begin
		hv_s2     <= hv_full[FW-1:0];
		hu_s2     <= hu_full[FW-1:0];
		xv_s2     <= xv_full;
		xu_s2     <= xu_full;
		corner_s2 <= corner_s1;
		last_s2   <= last_s1;
	end

	// Stage 3: small quotient estimate by the same reciprocal
	assign qev_full = {{QW{1'b0}}, xv_s2} * {{XW{1'b0}}, base_v};
	assign qeu_full = {{QW{1'b0}}, xu_s2} * {{XW{1'b0}}, base_u};

	always_ff @(posedge clk) begin
		qev_s3    <= qev_full[XW+31:32];
		qeu_s3    <= qeu_full[XW+31:32];
		xv_s3     <= xv_s2;
		xu_s3     <= xu_s2;
		hv_s3     <= hv_s2;
		hu_s3     <= hu_s2;
		corner_s3 <= corner_s2;
		last_s3   <= last_s2;
	end

	// Stage 4: correct by one, full quotient floor(index * 2^32 / c)
	assign qcv_full = {{CW{1'b0}}, qev_s3} * {{XW{1'b0}}, stack_eff};
	assign qcu_full = {{CW{1'b0}}, qeu_s3} * {{XW{1'b0}}, slice_eff};
	assign rv       = xv_s3 - qcv_full[XW-1:0];
	assign ru       = xu_s3 - qcu_full[XW-1:0];
	assign qv_fix   = qev_s3 + {{(XW-1){1'b0}}, (rv >= {{(XW-CW){1'b0}}, stack_eff})};
	assign qu_fix   = qeu_s3 + {{(XW-1){1'b0}}, (ru >= {{(XW-CW){1'b0}}, slice_eff})};

	always_ff @(posedge clk) begin
		qv_s4     <= hv_s3 + {{(FW-XW){1'b0}}, qv_fix};
		qu_s4     <= hu_s3 + {{(FW-XW){1'b0}}, qu_fix};
		corner_s4 <= corner_s3;
		last_s4   <= last_s3;
	end

	// Stage 5: turn phases and texture coordinates
	assign tv_hi = qv_s4[FW-1:16];
	assign tu_hi = qu_s4[FW-1:16];

	always_ff @(posedge clk) begin
		ph_sp_s5 <= qv_s4[PW:1];
		ph_cp_s5 <= qv_s4[PW:1] + uvs_pkg::QUARTER_TURN;
		ph_sa_s5 <= qu_s4[PW-1:0];
		ph_ca_s5 <= qu_s4[PW-1:0] + uvs_pkg::QUARTER_TURN;
		side_s5.tex_v  <= (tv_hi > {{(FW-16-OW){1'b0}}, uvs_pkg::TEX_ONE}) ?
		                  uvs_pkg::TEX_ONE : tv_hi[OW-1:0];
		side_s5.tex_u  <= (tu_hi > {{(FW-16-OW){1'b0}}, uvs_pkg::TEX_ONE}) ?
		                  uvs_pkg::TEX_ONE : tu_hi[OW-1:0];
		side_s5.corner <= corner_s4;
		side_s5.last   <= last_s4;
	end

	// Sine and cosine of polar and azimuth
	uvs_sine #(.TRIG_BITS(TRIG_BITS)) u_sin_p (
		.clk (clk), .phase (ph_sp_s5), .mag (sp_mag), .neg (sp_neg)
	);
	uvs_sine #(.TRIG_BITS(TRIG_BITS)) u_cos_p (
		.clk (clk), .phase (ph_cp_s5), .mag (cp_mag), .neg (cp_neg)
	);
	uvs_sine #(.TRIG_BITS(TRIG_BITS)) u_sin_a (
		.clk (clk), .phase (ph_sa_s5), .mag (sa_mag), .neg (sa_neg)
	);
	uvs_sine #(.TRIG_BITS(TRIG_BITS)) u_cos_a (
		.clk (clk), .phase (ph_ca_s5), .mag (ca_mag), .neg (ca_neg)
	);

	uvs_delay #(.W($bits(side_t)), .DEPTH(uvs_pkg::SIN_LAT)) u_side (
		.clk     (clk),
		.arst_n  (arst_n),
		.d_valid (v_s5),
		.d_data  (side_s5),
		.q_valid (v_d),
		.q_data  (side_d)
	);

	// Valid bits of the back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s6 <= v_d;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Stage 6: radius products
	assign rsp_full = {{TRIG_BITS{1'b0}}, radius_q} * {{RW{1'b0}}, sp_mag};
	assign rcp_full = {{TRIG_BITS{1'b0}}, radius_q} * {{RW{1'b0}}, cp_mag};

	always_ff @(posedge clk) begin
		rsp_s6  <= rsp_full;
		my_s6   <= rcp_full[F+RW-1:F];
		sa_s6   <= sa_mag;
		ca_s6   <= ca_mag;
		nsp_s6  <= sp_neg;
		ncp_s6  <= cp_neg;
		nsa_s6  <= sa_neg;
		nca_s6  <= ca_neg;
		side_s6 <= side_d;
	end

	// Stage 7: second factor for x and z, truncated
	assign mx_full = {{TRIG_BITS{1'b0}}, rsp_s6} * {{(RW+TRIG_BITS){1'b0}}, sa_s6};
	assign mz_full = {{TRIG_BITS{1'b0}}, rsp_s6} * {{(RW+TRIG_BITS){1'b0}}, ca_s6};

	always_ff @(posedge clk) begin
		mx_s7   <= mx_full[2*F+RW-1:2*F];
		mz_s7   <= mz_full[2*F+RW-1:2*F];
		my_s7   <= my_s6;
		nx_s7   <= (nsp_s6 == nsa_s6);
		ny_s7   <= ncp_s6;
		nz_s7   <= (nsp_s6 == nca_s6);
		side_s7 <= side_s6;
	end

	// Stage 8: apply signs, output registers
	always_ff @(posedge clk) begin
		px_s8   <= (nx_s7 && mx_s7 != '0) ? (OW'(0) - {1'b0, mx_s7}) : {1'b0, mx_s7};
		py_s8   <= (ny_s7 && my_s7 != '0) ? (OW'(0) - {1'b0, my_s7}) : {1'b0, my_s7};
		pz_s8   <= (nz_s7 && mz_s7 != '0) ? (OW'(0) - {1'b0, mz_s7}) : {1'b0, mz_s7};
		side_s8 <= side_s7;
	end

	assign vertex_valid = v_s8;
	assign pos_x        = $signed(px_s8);
	assign pos_y        = $signed(py_s8);
	assign pos_z        = $signed(pz_s8);
	assign tex_u        = side_s8.tex_u;
	assign tex_v        = side_s8.tex_v;
	assign corner       = side_s8.corner;
	assign last         = side_s8.last;

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// UV sphere vertex generator testbench
// Sends quad requests through the start/busy handshake and predicts the six
// vertices of each quad with a fixed-point sphere model kept in the bench.
// Each vertex strobe is checked field by field against the oldest pending
// prediction. Directed cases cover poles, quarter turns, field extremes,
// degenerate and oversized counts and a write to an unused register index.
// Random phases follow, with new register settings and bursty request pacing.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_STACKS    = 256;
	localparam int MAX_SLICES    = 256;
	localparam int TRIG_BITS     = 16;
	localparam int TRIG_FRAC     = TRIG_BITS - 1;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;
	localparam logic [uvs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int DRAIN_CYCLES  = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int REPORT_CAP    = 40;
	localparam int SWEEP_PHASES  = 8;
	localparam int SWEEP_ITEMS   = 48;

	// Grid offsets of the six corners of a quad
	localparam int STACK_STEP [6] = '{0, 0, 1, 0, 1, 1};
	localparam int SLICE_STEP [6] = '{0, 1, 0, 1, 1, 0};

	typedef struct packed {
		logic [uvs_pkg::OUT_W-1:0]    pos_x;
		logic [uvs_pkg::OUT_W-1:0]    pos_y;
		logic [uvs_pkg::OUT_W-1:0]    pos_z;
		logic [uvs_pkg::OUT_W-1:0]    tex_u;
		logic [uvs_pkg::OUT_W-1:0]    tex_v;
		logic [uvs_pkg::CORNER_W-1:0] corner;
		logic                         last;
	} vertex_t;

	logic                                 clk;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_wr_en = 1'b0;
	logic [uvs_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
	logic [uvs_pkg::CFG_DATA_W-1:0]       cfg_data = '0;
	logic                                 start = 1'b0;
	logic                                 busy;
	logic [uvs_pkg::INDEX_W-1:0]          stack_index = '0;
	logic [uvs_pkg::INDEX_W-1:0]          slice_index = '0;
	logic                                 vertex_valid;
	logic signed [uvs_pkg::OUT_W-1:0]     pos_x;
	logic signed [uvs_pkg::OUT_W-1:0]     pos_y;
	logic signed [uvs_pkg::OUT_W-1:0]     pos_z;
	logic [uvs_pkg::OUT_W-1:0]            tex_u;
	logic [uvs_pkg::OUT_W-1:0]            tex_v;
	logic [uvs_pkg::CORNER_W-1:0]         corner;
	logic                                 last;

	// Bench copy of the registers
	logic [uvs_pkg::RADIUS_W-1:0]         radius_q = uvs_pkg::RADIUS_RST;
	logic [uvs_pkg::COUNT_W-1:0]          stacks_q = uvs_pkg::COUNT_RST;
	logic [uvs_pkg::COUNT_W-1:0]          slices_q = uvs_pkg::COUNT_RST;

	vertex_t                     pending_vertices [$];
	int                          mismatches = 0;
	int                          quads_sent = 0;
	int                          vertices_seen = 0;
	int                          settings_used = 0;
	int                          cycle_count = 0;
	bit                          pacing_on = 1'b0;
	int                          burst_left = 0;

	uv_sphere_vertex_generator_unit #(
		.MAX_STACKS(MAX_STACKS),
		.MAX_SLICES(MAX_SLICES),
		.TRIG_BITS (TRIG_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start       (start),
		.busy        (busy),
		.stack_index (stack_index),
		.slice_index (slice_index),
		.vertex_valid(vertex_valid),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.tex_u       (tex_u),
		.tex_v       (tex_v),
		.corner      (corner),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Sphere model
	// ------------------------------------------------------------------

	// zero acts as one, oversized counts clamp to the maximum
	function automatic int unsigned effective_count(logic [uvs_pkg::COUNT_W-1:0] c,
		int unsigned cap);
		if (c == 0) return 1;
		if (c > cap) return cap;
		return c;
	endfunction

	// truncated fraction of a full turn, angle wraps by whole turns
	function automatic logic [uvs_pkg::PHASE_W-1:0] turn_fraction(longint unsigned num,
		longint unsigned den);
		longint unsigned rem;
		rem = num % den;
		return uvs_pkg::PHASE_W'((rem << 32) / den);
	endfunction

	// sine magnitude over the first quarter turn, f in Q2.30 quarter turns
	function automatic longint unsigned quarter_sine(longint unsigned f);
		longint unsigned t, t2, s;
		if (f >= ONE_Q30) return 64'd1 << TRIG_FRAC;
		t  = (f * 64'(uvs_pkg::HALF_PI_Q30)) >> 30;
		t2 = (t * t) >> 30;
		s  = ONE_Q30 - t2 / 110;
		s  = ONE_Q30 - ((t2 * s) >> 30) / 72;
		s  = ONE_Q30 - ((t2 * s) >> 30) / 42;
		s  = ONE_Q30 - ((t2 * s) >> 30) / 20;
		s  = ONE_Q30 - ((t2 * s) >> 30) / 6;
		s  = (t * s) >> 30;
		return s >> (30 - TRIG_FRAC);
	endfunction

	// sine of a turn phase by quadrant symmetry
	function automatic longint unsigned phase_sine(logic [uvs_pkg::PHASE_W-1:0] p,
		output bit neg);
		longint unsigned f, m;
		f = 64'(p[29:0]);
		m = p[30] ? quarter_sine(ONE_Q30 - f) : quarter_sine(f);
		neg = p[31] && (m != 0);
		return m;
	endfunction

	function automatic logic [uvs_pkg::OUT_W-1:0] signed_out(longint unsigned mag, bit neg);
		return neg ? uvs_pkg::OUT_W'(64'd0 - mag) : uvs_pkg::OUT_W'(mag);
	endfunction

	// grid index over count in Q1.16, saturating at one
	function automatic logic [uvs_pkg::OUT_W-1:0] grid_tex(longint unsigned idx,
		longint unsigned cnt);
		longint unsigned v;
		v = (idx * 65536) / cnt;
		return (v > 64'(uvs_pkg::TEX_ONE)) ? uvs_pkg::TEX_ONE : uvs_pkg::OUT_W'(v);
	endfunction

	function automatic vertex_t sphere_vertex(int unsigned a, int unsigned b, int k);
		longint unsigned ns, nl, r, sp, cp, sa, ca, mx, my, mz;
		logic [uvs_pkg::PHASE_W-1:0] pp, pa;
		bit nsp, ncp, nsa, nca;
		vertex_t v;
		ns = effective_count(stacks_q, MAX_STACKS);
		nl = effective_count(slices_q, MAX_SLICES);
		r  = 64'(radius_q);
		pp = turn_fraction(a, 2 * ns);
		pa = turn_fraction(b, nl);
		sp = phase_sine(pp, nsp);
		cp = phase_sine(pp + uvs_pkg::QUARTER_TURN, ncp);
		sa = phase_sine(pa, nsa);
		ca = phase_sine(pa + uvs_pkg::QUARTER_TURN, nca);
		mx = (r * sp * sa) >> (2 * TRIG_FRAC);
		my = (r * cp) >> TRIG_FRAC;
		mz = (r * sp * ca) >> (2 * TRIG_FRAC);
		// x and z carry a leading minus sign
		v.pos_x  = signed_out(mx, (nsp == nsa) && mx != 0);
		v.pos_y  = signed_out(my, ncp && my != 0);
		v.pos_z  = signed_out(mz, (nsp == nca) && mz != 0);
		v.tex_u  = grid_tex(b, nl);
		v.tex_v  = grid_tex(a, ns);
		v.corner = uvs_pkg::CORNER_W'(k);
		v.last   = (uvs_pkg::CORNER_W'(k) == uvs_pkg::CORNER_LAST);
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// register write; only called with nothing in flight
	task automatic cfg_write(input logic [uvs_pkg::CFG_IDX_W-1:0] idx,
		input logic [uvs_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			uvs_pkg::REG_RADIUS: radius_q = data;
			uvs_pkg::REG_STACK:  stacks_q = data[uvs_pkg::COUNT_W-1:0];
			uvs_pkg::REG_SLICE:  slices_q = data[uvs_pkg::COUNT_W-1:0];
			default: ;
		endcase
		settings_used++;
	endtask

	// present one quad and hold it until taken; start stays high for a burst
	task automatic send_quad(input logic [uvs_pkg::INDEX_W-1:0] i,
		input logic [uvs_pkg::INDEX_W-1:0] j);
		start       <= 1'b1;
		stack_index <= i;
		slice_index <= j;
		do @(posedge clk); while (busy);
		for (int k = 0; k < uvs_pkg::NUM_CORNERS; k++)
			pending_vertices.push_back(sphere_vertex(i + STACK_STEP[k], j + SLICE_STEP[k], k));
		quads_sent++;
	endtask

	// bursts of random length separated by random gaps
	task automatic pace();
		int gap;
		if (pacing_on) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
				burst_left = $urandom_range(1, 10);
				if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
	endtask

	// drop start and wait for every predicted vertex to come out
	task automatic wait_drained();
		int guard;
		guard = 0;
		start <= 1'b0;
		do begin
			@(posedge clk);
			guard++;
		end while (pending_vertices.size() != 0 && guard < DRAIN_CYCLES);
		if (pending_vertices.size() != 0) begin
			mismatches++;
			$error("%0d predicted vertices never came out", pending_vertices.size());
			pending_vertices.delete();
		end
	endtask

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [uvs_pkg::OUT_W-1:0] want,
		input logic [uvs_pkg::OUT_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$error("%s: expected 0x%05h, got 0x%05h", name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_vertex
		vertex_t want;
		if (arst_n && vertex_valid) begin
			if (pending_vertices.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$error("vertex with no pending prediction, corner %0d", corner);
			end else begin
				want = pending_vertices.pop_front();
				check_field("pos_x", want.pos_x, pos_x);
				check_field("pos_y", want.pos_y, pos_y);
				check_field("pos_z", want.pos_z, pos_z);
				check_field("tex_u", want.tex_u, tex_u);
				check_field("tex_v", want.tex_v, tex_v);
				check_field("corner", uvs_pkg::OUT_W'(want.corner), uvs_pkg::OUT_W'(corner));
				check_field("last", uvs_pkg::OUT_W'(want.last), uvs_pkg::OUT_W'(last));
				vertices_seen++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset registers: poles, quarter turns, wrap at the last slice
	task automatic test_reset_defaults();
		send_quad(8'd0, 8'd0);
		send_quad(8'd15, 8'd15);
		send_quad(8'd4, 8'd4);
		send_quad(8'd8, 8'd12);
	endtask

	// largest radius and counts, indexes at both ends
	task automatic test_field_extremes();
		wait_drained();
		cfg_write(uvs_pkg::REG_RADIUS, 16'hFFFF);
		cfg_write(uvs_pkg::REG_STACK, 16'd256);
		cfg_write(uvs_pkg::REG_SLICE, 16'd256);
		send_quad(8'd255, 8'd255);
		send_quad(8'd0, 8'd0);
		send_quad(8'd255, 8'd0);
		send_quad(8'd0, 8'd255);
		send_quad(8'd128, 8'd64);
	endtask

	// zero and oversized counts, zero radius, indexes past the count,
	// and a write to an index with no register behind it
	task automatic test_count_special_cases();
		wait_drained();
		cfg_write(uvs_pkg::REG_RADIUS, 16'h0180);
		cfg_write(uvs_pkg::REG_STACK, 16'd0);
		cfg_write(uvs_pkg::REG_SLICE, 16'd0);
		send_quad(8'd0, 8'd0);
		send_quad(8'd1, 8'd1);
		send_quad(8'd255, 8'd255);
		wait_drained();
		cfg_write(uvs_pkg::REG_RADIUS, 16'h0000);
		send_quad(8'd3, 8'd7);
		wait_drained();
		cfg_write(uvs_pkg::REG_RADIUS, 16'h2A5C);
		cfg_write(uvs_pkg::REG_STACK, 16'hFFFF);
		cfg_write(uvs_pkg::REG_SLICE, 16'd300);
		send_quad(8'd200, 8'd255);
		send_quad(8'd255, 8'd100);
		wait_drained();
		cfg_write(REG_UNUSED, 16'hFFFF);
		send_quad(8'd5, 8'd5);
	endtask

	// count value: mostly in range, some tiny, some raw 16-bit data
	function automatic logic [uvs_pkg::CFG_DATA_W-1:0] random_count();
		case ($urandom_range(0, 9))
			0:       return uvs_pkg::CFG_DATA_W'($urandom);
			1, 2:    return uvs_pkg::CFG_DATA_W'($urandom_range(1, 6));
			default: return uvs_pkg::CFG_DATA_W'($urandom_range(1, 256));
		endcase
	endfunction

	// random quads under a series of register settings
	task automatic test_random_sweep();
		int unsigned ns, nl;
		logic [uvs_pkg::INDEX_W-1:0] i, j;
		for (int ph = 0; ph < SWEEP_PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					cfg_write(uvs_pkg::REG_RADIUS, 16'hFFFF);
					cfg_write(uvs_pkg::REG_STACK, 16'd256);
					cfg_write(uvs_pkg::REG_SLICE, 16'd256);
				end
				1: begin
					cfg_write(uvs_pkg::REG_RADIUS, uvs_pkg::CFG_DATA_W'($urandom));
					cfg_write(uvs_pkg::REG_STACK, 16'd1);
					cfg_write(uvs_pkg::REG_SLICE, 16'd1);
				end
				7: begin
					cfg_write(uvs_pkg::REG_RADIUS, 16'd1);
					cfg_write(uvs_pkg::REG_STACK, 16'd2);
					cfg_write(uvs_pkg::REG_SLICE, 16'd3);
				end
				default: begin
					cfg_write(uvs_pkg::REG_RADIUS, uvs_pkg::CFG_DATA_W'($urandom));
					cfg_write(uvs_pkg::REG_STACK, random_count());
					cfg_write(uvs_pkg::REG_SLICE, random_count());
				end
			endcase
			// one phase runs back to back with no gaps
			pacing_on  = (ph != 2);
			burst_left = 0;
			ns = effective_count(stacks_q, MAX_STACKS);
			nl = effective_count(slices_q, MAX_SLICES);
			for (int n = 0; n < SWEEP_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 85) begin
					i = uvs_pkg::INDEX_W'($urandom_range(0, ns - 1));
					j = uvs_pkg::INDEX_W'($urandom_range(0, nl - 1));
				end else begin
					i = uvs_pkg::INDEX_W'($urandom);
					j = uvs_pkg::INDEX_W'($urandom);
				end
				pace();
				send_quad(i, j);
			end
		end
		pacing_on = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_field_extremes();
		test_count_special_cases();
		test_random_sweep();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d quads, checked %0d vertices over %0d register writes",
			quads_sent, vertices_seen, settings_used);
		$display("counts from zero to oversized, radius from 0 to 0xFFFF, bursty pacing");
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("run did not finish within %0d cycles", LIMIT_CYCLES);
		$display("status: fail");
		$finish;
	end

endmodule
